// ===== rtl/core/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst_n, expr)
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/bpgs_pkg.sv =====
package bpgs_pkg;

    localparam int NUM_BANDS   = 4;
    localparam int BAND_W      = 2;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic [1:0] CFG_BAND_ONE   = 2'd0;
    localparam logic [1:0] CFG_BAND_TWO   = 2'd1;
    localparam logic [1:0] CFG_BAND_THREE = 2'd2;
    localparam logic [1:0] CFG_MAX_ORDER  = 2'd3;

    localparam logic [6:0] RESET_BAND_ONE   = 7'd10;
    localparam logic [6:0] RESET_BAND_TWO   = 7'd20;
    localparam logic [6:0] RESET_BAND_THREE = 7'd50;
    localparam logic [6:0] RESET_MAX_ORDER  = 7'd100;

    localparam logic [2:0] STATUS_QUEUED   = 3'd0;
    localparam logic [2:0] STATUS_REJECTED = 3'd1;
    localparam logic [2:0] STATUS_FULL     = 3'd2;
    localparam logic [2:0] STATUS_TAKEN    = 3'd3;
    localparam logic [2:0] STATUS_EMPTY    = 3'd4;

    localparam logic FUNC_SUBMIT = 1'b0;
    localparam logic FUNC_TAKE   = 1'b1;

    typedef struct packed {
        logic              take;
        logic              reject;
        logic [BAND_W-1:0] band;
        logic [7:0]        tag;
        logic [6:0]        order;
    } req_entry_t;

    typedef struct packed {
        logic [7:0]  tag;
        logic [6:0]  order;
        logic [31:0] seq_num;
    } goal_entry_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_READ = 2'b10
    } back_state_t;

endpackage

// ===== rtl/core/banded_priority_goal_scheduler_core.sv =====
// submit: queue, then response registers; take: queue, goal store read, response registers
// throughput: one submit per cycle while rsp_stall and req_stall are low; a take holds the
// back end in BK_READ for the registered read of the goal store
// a two-entry request queue decouples the classifying front from the back end
// rst_n clears band pointers, fill counts, sequence and queue; limits return to defaults
// goal store contents are not cleared by reset, only counted entries are ever read
module banded_priority_goal_scheduler_core #(
    parameter int BAND_DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic              func,
    input  logic [7:0]        goal_tag,
    input  logic signed [7:0] order,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output logic [2:0]        status,
    output logic [7:0]        out_tag,
    output logic [6:0]        out_order,
    output logic [2:0]        out_priority,
    output logic [31:0]       out_sequence,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);
    import bpgs_pkg::*;

    logic       q_full;
    logic       q_push;
    logic       q_valid;
    logic       q_pop;
    req_entry_t q_push_data;
    req_entry_t q_pop_data;

    bpgs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .func      (func),
        .goal_tag  (goal_tag),
        .order     (order),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    bpgs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data),
        .pop       (q_pop)
    );

    bpgs_back #(
        .BAND_DEPTH (BAND_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_pop_data),
        .q_pop        (q_pop),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .out_tag      (out_tag),
        .out_order    (out_order),
        .out_priority (out_priority),
        .out_sequence (out_sequence)
    );

endmodule

// ===== rtl/core/bpgs_front.sv =====
module bpgs_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  logic                 func,
    input  logic [7:0]           goal_tag,
    input  logic signed [7:0]    order,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [6:0]           cfg_data,
    input  logic                 q_full,
    output logic                 q_push,
    output bpgs_pkg::req_entry_t q_data
);
    import bpgs_pkg::*;

    logic [6:0] band_one_reg;
    logic [6:0] band_two_reg;
    logic [6:0] band_three_reg;
    logic [6:0] max_order_reg;
    logic [6:0] raw;
    logic       reject;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_one_reg   <= RESET_BAND_ONE;
            band_two_reg   <= RESET_BAND_TWO;
            band_three_reg <= RESET_BAND_THREE;
            max_order_reg  <= RESET_MAX_ORDER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BAND_ONE:   band_one_reg   <= cfg_data;
                CFG_BAND_TWO:   band_two_reg   <= cfg_data;
                CFG_BAND_THREE: band_three_reg <= cfg_data;
                CFG_MAX_ORDER:  max_order_reg  <= cfg_data;
                default:        band_one_reg   <= band_one_reg;
            endcase
        end
    end

    assign raw    = order[6:0];
    assign reject = order[7] || (raw == 7'd0) || (raw > max_order_reg);

    always_comb
    begin
        q_data        = '0;
        q_data.take   = (func == FUNC_TAKE);
        q_data.reject = reject;
        q_data.tag    = goal_tag;
        q_data.order  = raw;
        if (raw <= band_one_reg)
            q_data.band = 2'd0;
        else if (raw <= band_two_reg)
            q_data.band = 2'd1;
        else if (raw <= band_three_reg)
            q_data.band = 2'd2;
        else
            q_data.band = 2'd3;
    end

    assign req_stall = q_full;
    assign q_push    = req_valid && !q_full;

endmodule

// ===== rtl/core/bpgs_queue.sv =====
module bpgs_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  bpgs_pkg::req_entry_t push_data,
    output logic                 full,
    output logic                 pop_valid,
    output bpgs_pkg::req_entry_t pop_data,
    input  logic                 pop
);
    import bpgs_pkg::*;

    req_entry_t             entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign full      = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && pop_valid))
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (!push && pop && pop_valid)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            if (pop && pop_valid)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== rtl/core/bpgs_back.sv =====
`include "assert_macros.svh"

module bpgs_back #(
    parameter int BAND_DEPTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  bpgs_pkg::req_entry_t q_data,
    output logic                 q_pop,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output logic [2:0]           status,
    output logic [7:0]           out_tag,
    output logic [6:0]           out_order,
    output logic [2:0]           out_priority,
    output logic [31:0]          out_sequence
);
    import bpgs_pkg::*;

    localparam int PTR_W  = $clog2(BAND_DEPTH);
    localparam int FILL_W = $clog2(BAND_DEPTH + 1);
    localparam int ADDR_W = $clog2(NUM_BANDS * BAND_DEPTH);

    goal_entry_t        mem [NUM_BANDS * BAND_DEPTH];
    goal_entry_t        rd_data_reg;

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [PTR_W-1:0]   head_reg [NUM_BANDS];
    logic [PTR_W-1:0]   tail_reg [NUM_BANDS];
    logic [FILL_W-1:0]  fill_reg [NUM_BANDS];
    logic [31:0]        seq_reg;
    logic [BAND_W-1:0]  take_band_reg;

    logic               rsp_valid_reg;
    logic [2:0]         status_reg;
    logic [7:0]         tag_reg;
    logic [6:0]         order_reg;
    logic [2:0]         prio_reg;
    logic [31:0]        sequence_reg;

    logic               out_free;
    logic               any_ready;
    logic [BAND_W-1:0]  sel_band;
    logic               band_full;
    logic               do_write;
    logic               do_read;
    logic               load;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    goal_entry_t        wr_data;
    logic [2:0]         status_next;
    logic [7:0]         tag_next;
    logic [6:0]         order_next;
    logic [2:0]         prio_next;
    logic [31:0]        sequence_next;
    logic               fill_in_range;

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
        return (pos == PTR_W'(BAND_DEPTH - 1)) ? '0 : pos + PTR_W'(1);
    endfunction

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign q_pop    = (state_reg == BK_IDLE) && q_valid && out_free;

    always_comb
    begin
        any_ready = 1'b1;
        if (fill_reg[3] != '0)
            sel_band = 2'd3;
        else if (fill_reg[2] != '0)
            sel_band = 2'd2;
        else if (fill_reg[1] != '0)
            sel_band = 2'd1;
        else
        begin
            sel_band  = 2'd0;
            any_ready = (fill_reg[0] != '0);
        end
    end

    assign band_full = (fill_reg[q_data.band] == FILL_W'(BAND_DEPTH));
    assign wr_addr   = ADDR_W'(q_data.band) * ADDR_W'(BAND_DEPTH)
                     + ADDR_W'(tail_reg[q_data.band]);
    assign rd_addr   = ADDR_W'(sel_band) * ADDR_W'(BAND_DEPTH)
                     + ADDR_W'(head_reg[sel_band]);

    always_comb
    begin
        wr_data.tag     = q_data.tag;
        wr_data.order   = q_data.order;
        wr_data.seq_num = seq_reg;
    end

    always_comb
    begin
        state_next    = state_reg;
        do_write      = 1'b0;
        do_read       = 1'b0;
        load          = 1'b0;
        status_next   = STATUS_EMPTY;
        tag_next      = '0;
        order_next    = '0;
        prio_next     = '0;
        sequence_next = '0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_pop)
                begin
                    if (!q_data.take)
                    begin
                        load = 1'b1;
                        if (q_data.reject)
                            status_next = STATUS_REJECTED;
                        else if (band_full)
                        begin
                            status_next = STATUS_FULL;
                            prio_next   = {1'b0, q_data.band} + 3'd1;
                        end
                        else
                        begin
                            do_write      = 1'b1;
                            status_next   = STATUS_QUEUED;
                            tag_next      = q_data.tag;
                            order_next    = q_data.order;
                            prio_next     = {1'b0, q_data.band} + 3'd1;
                            sequence_next = seq_reg;
                        end
                    end
                    else if (!any_ready)
                    begin
                        load        = 1'b1;
                        status_next = STATUS_EMPTY;
                    end
                    else
                    begin
                        do_read    = 1'b1;
                        state_next = BK_READ;
                    end
                end
            end
            BK_READ:
            begin
                load          = 1'b1;
                status_next   = STATUS_TAKEN;
                tag_next      = rd_data_reg.tag;
                order_next    = rd_data_reg.order;
                prio_next     = {1'b0, take_band_reg} + 3'd1;
                sequence_next = rd_data_reg.seq_num;
                state_next    = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            seq_reg       <= '0;
            take_band_reg <= '0;
            rsp_valid_reg <= 1'b0;
            for (int b = 0; b < NUM_BANDS; b++)
            begin
                head_reg[b] <= '0;
                tail_reg[b] <= '0;
                fill_reg[b] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (do_write)
            begin
                tail_reg[q_data.band] <= ring_next(tail_reg[q_data.band]);
                fill_reg[q_data.band] <= fill_reg[q_data.band] + FILL_W'(1);
                seq_reg               <= seq_reg + 32'd1;
            end
            if (do_read)
            begin
                head_reg[sel_band] <= ring_next(head_reg[sel_band]);
                fill_reg[sel_band] <= fill_reg[sel_band] - FILL_W'(1);
                take_band_reg      <= sel_band;
            end
            if (load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_write)
            mem[wr_addr] <= wr_data;
        if (do_read)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg   <= status_next;
            tag_reg      <= tag_next;
            order_reg    <= order_next;
            prio_reg     <= prio_next;
            sequence_reg <= sequence_next;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign out_tag      = tag_reg;
    assign out_order    = order_reg;
    assign out_priority = prio_reg;
    assign out_sequence = sequence_reg;

    always_comb
    begin
        fill_in_range = 1'b1;
        for (int b = 0; b < NUM_BANDS; b++)
        begin
            if (fill_reg[b] > FILL_W'(BAND_DEPTH))
                fill_in_range = 1'b0;
        end
    end

    `ASSERT_ALWAYS(a_state_onehot, clk, rst_n, $onehot(state_reg))
    `ASSERT_IMPLY(a_read_out_empty, clk, rst_n, state_reg == BK_READ, !rsp_valid_reg)
    `ASSERT_ALWAYS(a_fill_bound, clk, rst_n, fill_in_range)
    `ASSERT_IMPLY(a_seq_step, clk, rst_n, !$stable(seq_reg), seq_reg == $past(seq_reg) + 32'd1)
    `ASSERT_IMPLY(a_read_after_take, clk, rst_n, state_reg == BK_READ, $past(q_pop && q_data.take))

endmodule
